### rtl/scfd_pkg.sv
// scfd_pkg: shared constants, reply kinds and text lookup functions for the
// serial command frame decoder. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package scfd_pkg;

  // default frame buffer depth in bytes
  localparam int unsigned BUFFER_BYTES_DEF = 64;

  // width of the serial channel byte and of the device state
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned DEV_W  = 3;

  // command table: six on/off commands then the status query
  localparam int unsigned CMD_COUNT  = 7;
  localparam logic [2:0]  CMD_STATUS = 3'd6;

  // frame end marker
  localparam logic [7:0] MARK_V = 8'h56;
  localparam logic [7:0] MARK_E = 8'h45;
  localparam logic [7:0] MARK_N = 8'h4E;
  localparam logic [7:0] MARK_D = 8'h44;

  // bytes around the payload: two lead bytes and the four marker bytes
  localparam int unsigned FRAME_OVERHEAD = 6;
  localparam int unsigned LEAD_BYTES     = 2;

  // reply text
  localparam logic [127:0] OK_TEXT     = 128'({"U_set", "OK_VEND"});
  localparam logic [127:0] CANCEL_TEXT = 128'({"U_set", "CANCEL_VEND"});
  localparam logic [127:0] VEND_TEXT   = 128'("_VEND");
  localparam logic [7:0]   CHAR_U      = 8'h55;
  localparam logic [7:0]   CHAR_USCORE = 8'h5F;
  localparam logic [4:0]   STATUS_DIGIT_HI = 5'b00110;

  typedef enum logic [1:0] {
    RK_OK,
    RK_STATUS,
    RK_CANCEL
  } reply_kind_t;

  // character at position pos of a right-justified string of n characters
  function automatic logic [7:0] str_char(input logic [127:0] s, input logic [4:0] n,
                                          input logic [3:0] pos);
    logic [7:0]  ch;
    int unsigned sh;
    ch = '0;
    sh = 0;
    if ({1'b0, pos} < n) begin
      sh = 8 * (int'(n) - 1 - int'(pos));
      ch = s[sh +: 8];
    end
    return ch;
  endfunction

  // command text, payload form
  function automatic logic [127:0] cmd_text(input logic [2:0] c);
    logic [127:0] t;
    case (c)
      3'd0:    t = 128'("deviceoneon");
      3'd1:    t = 128'("deviceoneoff");
      3'd2:    t = 128'("devicetwoon");
      3'd3:    t = 128'("devicetwooff");
      3'd4:    t = 128'("devicethreeon");
      3'd5:    t = 128'("devicethreeoff");
      3'd6:    t = 128'("statusdevices");
      default: t = '0;
    endcase
    return t;
  endfunction

  function automatic logic [4:0] cmd_len(input logic [2:0] c);
    logic [4:0] n;
    case (c)
      3'd0:    n = 5'd11;
      3'd1:    n = 5'd12;
      3'd2:    n = 5'd11;
      3'd3:    n = 5'd12;
      3'd4:    n = 5'd13;
      3'd5:    n = 5'd14;
      3'd6:    n = 5'd13;
      default: n = 5'd0;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] cmd_char(input logic [2:0] c, input logic [3:0] pos);
    return str_char(cmd_text(c), cmd_len(c), pos);
  endfunction

  // reply length in bytes
  function automatic logic [4:0] reply_len(input reply_kind_t k);
    logic [4:0] n;
    case (k)
      RK_OK:     n = 5'd12;
      RK_STATUS: n = 5'd8;
      RK_CANCEL: n = 5'd16;
      default:   n = 5'd16;
    endcase
    return n;
  endfunction

  // reply byte at position idx; the status reply carries the device digit
  function automatic logic [7:0] reply_char(input reply_kind_t k, input logic [3:0] idx,
                                            input logic [2:0] dev);
    logic [7:0] ch;
    case (k)
      RK_OK:     ch = str_char(OK_TEXT, 5'd12, idx);
      RK_CANCEL: ch = str_char(CANCEL_TEXT, 5'd16, idx);
      RK_STATUS: begin
        if (idx == 4'd0) begin
          ch = CHAR_U;
        end else if (idx == 4'd1) begin
          ch = CHAR_USCORE;
        end else if (idx == 4'd2) begin
          ch = {STATUS_DIGIT_HI, dev};
        end else begin
          ch = str_char(VEND_TEXT, 5'd5, idx - 4'd3);
        end
      end
      default:   ch = '0;
    endcase
    return ch;
  endfunction

endpackage

`default_nettype wire

### rtl/scfd_if.sv
// scfd_if: valid/ready channel interfaces for received bytes and reply bytes.
// Depends on scfd_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface scfd_rx_if;
  logic                        valid;
  logic                        ready;
  logic [scfd_pkg::BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface scfd_reply_if;
  logic                        valid;
  logic                        ready;
  logic [scfd_pkg::BYTE_W-1:0] reply_byte;
  logic                        reply_last;
  logic [scfd_pkg::DEV_W-1:0]  device_bits;

  modport source (output valid, output reply_byte, output reply_last, output device_bits,
                  input ready);
  modport sink   (input valid, input reply_byte, input reply_last, input device_bits,
                  output ready);
endinterface

`default_nettype wire

### rtl/scfd_ram.sv
// scfd_ram: generic single write port, single read port RAM with registered
// read data. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module scfd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### rtl/serial_command_frame_decoder.sv
// serial_command_frame_decoder: frame collection, command match sequencer
// and reply streamer. Depends on scfd_pkg, scfd_if and scfd_ram.
`timescale 1ns / 1ps
`default_nettype none

// Collects received bytes into a frame buffer and closes the frame when the
// last four bytes read V,E,N,D. The payload (frame minus two lead bytes and
// the marker) is matched against six device on/off commands and a status
// query, and a reply string is streamed out one byte per request, the final
// byte flagged by reply_last; device_bits shows the device state after the
// frame's command. A byte that does not close a frame is taken and the block
// stays ready for the next one. A closing byte holds the input off while the
// payload is walked through the frame RAM's single read port, one byte per
// cycle, when the payload has the length of a command (11 to 14 bytes) and
// not otherwise, ending early once every command has mismatched; then 8, 12
// or 16 reply bytes go out at one per cycle when the sink is always ready,
// and the next byte is taken on the cycle after the final reply byte.
// Bytes past BUFFER_BYTES are dropped and the frame gets the cancel reply.
module serial_command_frame_decoder #(
  parameter int unsigned BUFFER_BYTES = scfd_pkg::BUFFER_BYTES_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  scfd_rx_if.sink     in_ch,
  scfd_reply_if.source out_ch
);

  localparam int unsigned AW    = $clog2(BUFFER_BYTES);
  localparam int unsigned LEN_W = $clog2(BUFFER_BYTES + 1);
  localparam int unsigned NC    = scfd_pkg::CMD_COUNT;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MATCH,
    ST_REPLY
  } state_t;

  state_t                 state_r, state_nxt;
  logic [LEN_W-1:0]       len_r, len_nxt;
  logic                   ovf_r, ovf_nxt;
  logic [23:0]            recent_r, recent_nxt;
  logic [2:0]             dev_r, dev_nxt;
  logic [NC-1:0]          mask_r, mask_nxt;
  logic [3:0]             plen_r, plen_nxt;
  logic [3:0]             rd_idx_r, rd_idx_nxt;
  logic [3:0]             cmp_idx_r, cmp_idx_nxt;
  logic                   cmp_vld_r, cmp_vld_nxt;
  scfd_pkg::reply_kind_t  kind_r, kind_nxt;
  logic [3:0]             reply_idx_r, reply_idx_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [7:0]             out_byte_r, out_byte_nxt;
  logic                   out_last_r, out_last_nxt;

  logic                   accept;
  logic                   len_full;
  logic [LEN_W-1:0]       len_inc;
  logic [LEN_W-1:0]       plen_full;
  logic                   ovf_acc;
  logic                   marker;
  logic [NC-1:0]          cand;
  logic                   issue;
  logic [2:0]             hit;
  logic [2:0]             hit_mask;
  logic [7:0]             ram_rdata;
  logic [AW-1:0]          ram_raddr;

  // frame buffer
  scfd_ram #(
    .WIDTH (scfd_pkg::BYTE_W),
    .DEPTH (BUFFER_BYTES)
  ) u_frame_ram (
    .clk   (clk),
    .we    (accept && !len_full),
    .waddr (len_r[AW-1:0]),
    .wdata (in_ch.rx_byte),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign ram_raddr = AW'(rd_idx_r) + AW'(scfd_pkg::LEAD_BYTES);

  // handshake and outputs
  assign in_ch.ready        = (state_r == ST_IDLE);
  assign accept             = in_ch.valid && in_ch.ready;
  assign out_ch.valid       = out_valid_r;
  assign out_ch.reply_byte  = out_byte_r;
  assign out_ch.reply_last  = out_last_r;
  assign out_ch.device_bits = dev_r;

  // frame length bookkeeping and marker detect
  assign len_full  = (len_r == LEN_W'(BUFFER_BYTES));
  assign len_inc   = len_full ? len_r : len_r + LEN_W'(1);
  assign ovf_acc   = ovf_r || len_full;
  assign plen_full = len_inc - LEN_W'(scfd_pkg::FRAME_OVERHEAD);
  assign marker    = (ovf_acc || len_inc >= LEN_W'(4)) &&
                     in_ch.rx_byte == scfd_pkg::MARK_D &&
                     recent_r[23:16] == scfd_pkg::MARK_V &&
                     recent_r[15:8] == scfd_pkg::MARK_E &&
                     recent_r[7:0] == scfd_pkg::MARK_N;

  // commands whose length matches the payload
  always_comb begin
    for (int c = 0; c < NC; c++) begin
      cand[c] = (plen_full == LEN_W'(scfd_pkg::cmd_len(3'(c))));
    end
  end

  // first surviving command
  always_comb begin
    hit = scfd_pkg::CMD_STATUS;
    for (int c = NC - 1; c >= 0; c--) begin
      if (mask_r[c]) begin
        hit = 3'(c);
      end
    end
  end

  assign hit_mask = 3'b001 << hit[2:1];
  assign issue    = (mask_r != '0) && (rd_idx_r != plen_r);

  // sequencer next state
  always_comb begin
    state_nxt     = state_r;
    len_nxt       = len_r;
    ovf_nxt       = ovf_r;
    recent_nxt    = recent_r;
    dev_nxt       = dev_r;
    mask_nxt      = mask_r;
    plen_nxt      = plen_r;
    rd_idx_nxt    = rd_idx_r;
    cmp_idx_nxt   = cmp_idx_r;
    cmp_vld_nxt   = 1'b0;
    kind_nxt      = kind_r;
    reply_idx_nxt = reply_idx_r;
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    case (state_r)
      // collect bytes, close on marker
      ST_IDLE: begin
        if (accept) begin
          if (marker) begin
            len_nxt    = '0;
            ovf_nxt    = 1'b0;
            recent_nxt = '0;
            rd_idx_nxt = '0;
            plen_nxt   = plen_full[3:0];
            if (ovf_acc || len_inc < LEN_W'(scfd_pkg::FRAME_OVERHEAD)) begin
              mask_nxt = '0;
            end else begin
              mask_nxt = cand;
            end
            state_nxt = ST_MATCH;
          end else begin
            len_nxt    = len_inc;
            ovf_nxt    = ovf_acc;
            recent_nxt = {recent_r[15:0], in_ch.rx_byte};
          end
        end
      end
      // walk payload bytes, drop mismatching commands
      ST_MATCH: begin
        if (issue) begin
          rd_idx_nxt  = rd_idx_r + 4'd1;
          cmp_vld_nxt = 1'b1;
          cmp_idx_nxt = rd_idx_r;
        end
        if (cmp_vld_r) begin
          for (int c = 0; c < NC; c++) begin
            if (ram_rdata != scfd_pkg::cmd_char(3'(c), cmp_idx_r)) begin
              mask_nxt[c] = 1'b0;
            end
          end
        end
        if (!issue && !cmp_vld_r) begin
          if (mask_r == '0) begin
            kind_nxt = scfd_pkg::RK_CANCEL;
          end else if (hit == scfd_pkg::CMD_STATUS) begin
            kind_nxt = scfd_pkg::RK_STATUS;
          end else begin
            kind_nxt = scfd_pkg::RK_OK;
            if (!hit[0]) begin
              dev_nxt = dev_r | hit_mask;
            end else begin
              dev_nxt = dev_r & ~hit_mask;
            end
          end
          out_valid_nxt = 1'b1;
          out_byte_nxt  = scfd_pkg::CHAR_U;
          out_last_nxt  = 1'b0;
          reply_idx_nxt = 4'd1;
          state_nxt     = ST_REPLY;
        end
      end
      // stream reply bytes
      ST_REPLY: begin
        if (out_ch.ready) begin
          if (out_last_r) begin
            out_valid_nxt = 1'b0;
            state_nxt     = ST_IDLE;
          end else begin
            out_byte_nxt  = scfd_pkg::reply_char(kind_r, reply_idx_r, dev_r);
            out_last_nxt  = ({1'b0, reply_idx_r} == scfd_pkg::reply_len(kind_r) - 5'd1);
            reply_idx_nxt = reply_idx_r + 4'd1;
          end
        end
      end
      default: begin
        state_nxt     = ST_IDLE;
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      len_r       <= '0;
      ovf_r       <= 1'b0;
      recent_r    <= '0;
      dev_r       <= '0;
      mask_r      <= '0;
      rd_idx_r    <= '0;
      cmp_vld_r   <= 1'b0;
      kind_r      <= scfd_pkg::RK_CANCEL;
      reply_idx_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      len_r       <= len_nxt;
      ovf_r       <= ovf_nxt;
      recent_r    <= recent_nxt;
      dev_r       <= dev_nxt;
      mask_r      <= mask_nxt;
      rd_idx_r    <= rd_idx_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      kind_r      <= kind_nxt;
      reply_idx_r <= reply_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
    plen_r     <= plen_nxt;
    cmp_idx_r  <= cmp_idx_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

  // no new byte taken while a reply is pending
  a_ready_excl: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> !out_ch.valid)
    else $error("input ready while reply pending");

  // reply ends after its flagged byte
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.ready && out_ch.reply_last) |=> !out_ch.valid)
    else $error("reply continues after last byte");

  // device state holds during a reply
  a_dev_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |=> (!out_ch.valid || $stable(out_ch.device_bits)))
    else $error("device bits changed during reply");

  // frame length bounded by buffer
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= LEN_W'(BUFFER_BYTES))
    else $error("frame length past buffer");

endmodule

`default_nettype wire

### verif/scfd_reply_checker.sv
// scfd_reply_checker: watches the byte and reply channels of the frame decoder,
// predicts every reply byte from the accepted bytes and compares.
// Depends on scfd_pkg for widths, marker bytes and reply kinds.
`timescale 1ns / 1ps

module scfd_reply_checker #(
  parameter int unsigned BUFFER_BYTES = scfd_pkg::BUFFER_BYTES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic [scfd_pkg::BYTE_W-1:0] in_rx_byte,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic [scfd_pkg::BYTE_W-1:0] out_reply_byte,
  input  logic                        out_reply_last,
  input  logic [scfd_pkg::DEV_W-1:0]  out_device_bits,
  output int                          pending_replies,
  output int                          mismatch_count
);

  typedef struct packed {
    logic [scfd_pkg::BYTE_W-1:0] data;
    logic                        last;
    logic [scfd_pkg::DEV_W-1:0]  dev;
  } reply_beat_t;

  // payload words, in match priority order; the status query is last
  string command_words [scfd_pkg::CMD_COUNT] = '{"deviceoneon", "deviceoneoff",
                                                 "devicetwoon", "devicetwooff",
                                                 "devicethreeon", "devicethreeoff",
                                                 "statusdevices"};

  // predicted decoder state
  logic [scfd_pkg::BYTE_W-1:0] frame_bytes [BUFFER_BYTES];
  int unsigned                 frame_len;
  logic                        frame_full;
  logic [23:0]                 recent;
  logic [scfd_pkg::DEV_W-1:0]  dev_state;

  reply_beat_t expected_replies[$];
  reply_beat_t head;
  int          errors = 0;

  // exact compare of the payload (frame minus lead bytes and marker) with a word
  function automatic logic payload_equals(input string w);
    if (int'(frame_len) - int'(scfd_pkg::FRAME_OVERHEAD) != w.len()) return 1'b0;
    for (int i = 0; i < w.len(); i++) begin
      if (frame_bytes[scfd_pkg::LEAD_BYTES + i] != w[i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // take one received byte; on a closing marker queue the whole reply
  task automatic predict_rx_byte(input logic [scfd_pkg::BYTE_W-1:0] b);
    logic                       closes;
    int                         hit;
    logic [scfd_pkg::DEV_W-1:0] mask;
    scfd_pkg::reply_kind_t      kind;
    string                      text;
    reply_beat_t                beat;
    if (frame_len < BUFFER_BYTES) begin
      frame_bytes[frame_len] = b;
      frame_len++;
    end else begin
      frame_full = 1'b1;
    end
    closes = (frame_full || frame_len >= 4) && b == scfd_pkg::MARK_D &&
             recent == {scfd_pkg::MARK_V, scfd_pkg::MARK_E, scfd_pkg::MARK_N};
    recent = {recent[15:0], b};
    if (closes) begin
      hit = -1;
      if (!frame_full && frame_len >= scfd_pkg::FRAME_OVERHEAD) begin
        for (int c = 0; c < scfd_pkg::CMD_COUNT; c++) begin
          if (hit < 0 && payload_equals(command_words[c])) hit = c;
        end
      end
      // even entries switch a device on, odd ones off
      if (hit < 0) begin
        kind = scfd_pkg::RK_CANCEL;
      end else if (hit == int'(scfd_pkg::CMD_STATUS)) begin
        kind = scfd_pkg::RK_STATUS;
      end else begin
        kind = scfd_pkg::RK_OK;
        mask = '0;
        mask[hit / 2] = 1'b1;
        if (hit % 2 == 0) dev_state = dev_state | mask;
        else dev_state = dev_state & ~mask;
      end
      case (kind)
        scfd_pkg::RK_OK:     text = $sformatf("U_set%s_VEND", "OK");
        scfd_pkg::RK_STATUS: text = $sformatf("U_%0d_VEND", dev_state);
        default:             text = $sformatf("U_set%s_VEND", "CANCEL");
      endcase
      for (int i = 0; i < text.len(); i++) begin
        beat.data = text[i];
        beat.last = (i == text.len() - 1);
        beat.dev  = dev_state;
        expected_replies.push_back(beat);
      end
      frame_len  = 0;
      frame_full = 1'b0;
      recent     = '0;
    end
  endtask

  // sample both channels at each edge
  always @(posedge clk) begin
    if (!rst_n) begin
      frame_len  = 0;
      frame_full = 1'b0;
      recent     = '0;
      dev_state  = '0;
      expected_replies.delete();
    end else begin
      if (in_valid && in_ready) predict_rx_byte(in_rx_byte);
      if (out_valid && out_ready) begin
        if (expected_replies.size() == 0) begin
          $error("reply byte %h with no request pending", out_reply_byte);
          errors++;
        end else begin
          head = expected_replies.pop_front();
          if (out_reply_byte !== head.data) begin
            $error("reply_byte: expected %h, actual %h", head.data, out_reply_byte);
            errors++;
          end
          if (out_reply_last !== head.last) begin
            $error("reply_last: expected %b, actual %b", head.last, out_reply_last);
            errors++;
          end
          if (out_device_bits !== head.dev) begin
            $error("device_bits: expected %h, actual %h", head.dev, out_device_bits);
            errors++;
          end
        end
      end
    end
    pending_replies <= expected_replies.size();
    mismatch_count  <= errors;
  end

endmodule

### verif/serial_command_frame_decoder_test.sv
// serial_command_frame_decoder_test: drives command frames, noise and overflow
// frames into the decoder under varied idling. Depends on scfd_pkg, scfd_if,
// the decoder RTL and scfd_reply_checker.
`timescale 1ns / 1ps

module serial_command_frame_decoder_test;

  localparam int unsigned TOTAL_BYTES = 230;
  localparam int unsigned QUIET_LIMIT = 4000;
  localparam int unsigned TAIL_CYCLES = 40;

  logic clk;
  logic rst_n;
  int   idle_pct = 0;
  int   stall_pct = 0;
  int   pending_replies;
  int   mismatch_count;

  logic [scfd_pkg::BYTE_W-1:0] frame_q[$];
  int unsigned                 bytes_sent = 0;

  string command_words [scfd_pkg::CMD_COUNT] = '{"deviceoneon", "deviceoneoff",
                                                 "devicetwoon", "devicetwooff",
                                                 "devicethreeon", "devicethreeoff",
                                                 "statusdevices"};

  scfd_rx_if    rx_ch ();
  scfd_reply_if reply_ch ();

  serial_command_frame_decoder u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (rx_ch),
    .out_ch (reply_ch)
  );

  scfd_reply_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (rx_ch.valid),
    .in_ready        (rx_ch.ready),
    .in_rx_byte      (rx_ch.rx_byte),
    .out_valid       (reply_ch.valid),
    .out_ready       (reply_ch.ready),
    .out_reply_byte  (reply_ch.reply_byte),
    .out_reply_last  (reply_ch.reply_last),
    .out_device_bits (reply_ch.device_bits),
    .pending_replies (pending_replies),
    .mismatch_count  (mismatch_count)
  );

  // 12 ns clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // reply sink with random back-pressure
  initial begin
    reply_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      reply_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // quiet-cycle watchdog
  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk);
      if ((rx_ch.valid && rx_ch.ready) || (reply_ch.valid && reply_ch.ready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("serial_command_frame_decoder_test failed");
    $finish;
  end

  function automatic void add_text(input string s);
    for (int i = 0; i < s.len(); i++) frame_q.push_back(s[i]);
  endfunction

  // random bytes with marker letters mixed in, so partial and early markers occur
  function automatic void add_noise(input int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(2) == 0) begin
        case ($urandom_range(3))
          0:       frame_q.push_back(scfd_pkg::MARK_V);
          1:       frame_q.push_back(scfd_pkg::MARK_E);
          2:       frame_q.push_back(scfd_pkg::MARK_N);
          default: frame_q.push_back(scfd_pkg::MARK_D);
        endcase
      end else begin
        frame_q.push_back(8'($urandom));
      end
    end
  endfunction

  // push every byte of frame_q as one request each, with random sender gaps
  task automatic send_frame();
    for (int i = 0; i < frame_q.size(); i++) begin
      while ($urandom_range(99) < idle_pct) begin
        rx_ch.valid <= 1'b0;
        @(posedge clk);
      end
      rx_ch.valid   <= 1'b1;
      rx_ch.rx_byte <= frame_q[i];
      do @(posedge clk); while (!rx_ch.ready);
      bytes_sent++;
    end
    frame_q.delete();
  endtask

  initial begin
    int unsigned                 directed_bytes;
    int unsigned                 frame_idx;
    int unsigned                 phase;
    int                          pick;
    int                          pos;
    string                       word;
    logic [scfd_pkg::BYTE_W-1:0] payload[$];

    rst_n         = 1'b0;
    rx_ch.valid   = 1'b0;
    rx_ch.rx_byte = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // shortest frame: marker alone
    add_text("VEND");
    send_frame();
    // empty payload, extreme lead bytes
    frame_q.push_back(8'h00);
    frame_q.push_back(8'hFF);
    add_text("VEND");
    send_frame();
    // status query right after reset
    frame_q.push_back(8'hFF);
    frame_q.push_back(8'h00);
    add_text("statusdevices");
    add_text("VEND");
    send_frame();
    directed_bytes = bytes_sent;

    frame_idx = 0;
    while (bytes_sent < TOTAL_BYTES) begin
      phase = (bytes_sent - directed_bytes) * 4 / (TOTAL_BYTES - directed_bytes);
      case (phase)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 82; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 82; end
        default: begin idle_pct = 13; stall_pct = 13; end
      endcase

      frame_q.push_back(8'($urandom));
      frame_q.push_back(8'($urandom));
      pick = $urandom_range(99);
      if (frame_idx < scfd_pkg::CMD_COUNT) begin
        // every command once, in table order
        add_text(command_words[frame_idx]);
      end else if (frame_idx == scfd_pkg::CMD_COUNT) begin
        // frame around the buffer size, from exactly full to overflowed
        add_noise(58 + $urandom_range(8));
      end else if (pick < 60) begin
        add_text(command_words[$urandom_range(scfd_pkg::CMD_COUNT - 1)]);
      end else if (pick < 78) begin
        // near miss of a command, including a zero byte inside the payload
        word = command_words[$urandom_range(scfd_pkg::CMD_COUNT - 1)];
        payload.delete();
        for (int i = 0; i < word.len(); i++) payload.push_back(word[i]);
        pos = $urandom_range(payload.size() - 1);
        case ($urandom_range(3))
          0:       payload[pos] = 8'($urandom);
          1:       void'(payload.pop_back());
          2:       payload.push_back(8'($urandom));
          default: payload.insert(pos, 8'h00);
        endcase
        foreach (payload[i]) frame_q.push_back(payload[i]);
      end else if (pick < 92) begin
        add_noise($urandom_range(12));
      end else begin
        // short frame, no payload room
        frame_q.delete();
        add_noise($urandom_range(1));
      end
      add_text("VEND");
      send_frame();
      frame_idx++;
    end
    rx_ch.valid <= 1'b0;

    do @(posedge clk); while (pending_replies != 0);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("serial_command_frame_decoder_test passed");
    end else begin
      $display("serial_command_frame_decoder_test failed");
    end
    $finish;
  end

endmodule
